@@ rtl/core/mfq_pkg.sv @@
// Shared types, codes and constants of the multilevel feedback queue scheduler.
// No dependencies; the top level and mfq_cfg refer to it by scoped names.
package mfq_pkg;

    localparam int LEVELS         = 5;
    localparam int LAST_LEVEL     = 4;
    localparam int TASK_SLOTS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 4;
    localparam int REM_W    = 8;
    localparam int EV_W     = 3;
    localparam int LEVEL_W  = 3;
    localparam int SLICE_W  = 5;
    localparam int THR_W    = 2;
    localparam int STREAK_W = 2;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 2'd3;

    localparam logic [MODE_W-1:0] MODE_ARRIVAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETIRE   = 2'd2;

    localparam logic [EV_W-1:0] EV_ACCEPTED    = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECTED    = 3'd1;
    localparam logic [EV_W-1:0] EV_DISPATCHED  = 3'd2;
    localparam logic [EV_W-1:0] EV_IDLE        = 3'd3;
    localparam logic [EV_W-1:0] EV_COMPLETED   = 3'd4;
    localparam logic [EV_W-1:0] EV_REQUEUED    = 3'd5;
    localparam logic [EV_W-1:0] EV_NOT_RUNNING = 3'd6;
    localparam logic [EV_W-1:0] EV_BUSY        = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

    localparam logic [SLICE_W-1:0] SLICE0_RST    = 5'd1;
    localparam logic [SLICE_W-1:0] SLICE1_RST    = 5'd2;
    localparam logic [SLICE_W-1:0] SLICE2_RST    = 5'd4;
    localparam logic [SLICE_W-1:0] SLICE3_RST    = 5'd8;
    localparam logic [SLICE_W-1:0] SLICE4_RST    = 5'd16;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 2'd2;

    typedef struct packed {
        logic [LEVELS-1:0][SLICE_W-1:0] slice;
        logic [THR_W-1:0]               threshold;
    } cfg_t;

    typedef struct packed {
        logic [REM_W-1:0]    remaining;
        logic [LEVEL_W-1:0]  level;
        logic [STREAK_W-1:0] streak;
    } task_entry_t;

    localparam int TASK_ENTRY_W = $bits(task_entry_t);

endpackage

@@ rtl/core/multilevel_feedback_queue_scheduler_unit.sv @@
// Top level of the multilevel feedback queue scheduler: control sequencer,
// level queue memory, task table memory. Depends on mfq_pkg, mfq_ram, mfq_cfg.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready  | s_mode, s_task_id, s_service_need
//   m_       | out       | m_valid / m_ready  | m_event_res, m_task_slot, m_level,
//            |           |                    | m_run_length, m_units_left
//   apb      | in/out    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// An item goes from the transfer through ST_EXEC to the output register, and a dispatch
// that pops a queue passes ST_POP first: the queue memory read must return the slot
// before the task table can be read. The next item is taken in the cycle after its
// predecessor's result is registered. A result that is not taken holds the sequencer in
// its final step; writes wait too. Synchronous active-low reset clears the queue
// pointers, active bits and the running task; both memories are left as they are.
module multilevel_feedback_queue_scheduler_unit #(
    parameter int TASK_SLOTS = mfq_pkg::TASK_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mfq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mfq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mfq_pkg::MODE_W-1:0]     s_mode,
    input  logic [mfq_pkg::ID_W-1:0]       s_task_id,
    input  logic [mfq_pkg::REM_W-1:0]      s_service_need,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mfq_pkg::EV_W-1:0]       m_event_res,
    output logic [mfq_pkg::ID_W-1:0]       m_task_slot,
    output logic [mfq_pkg::LEVEL_W-1:0]    m_level,
    output logic [mfq_pkg::SLICE_W-1:0]    m_run_length,
    output logic [mfq_pkg::REM_W-1:0]      m_units_left
);

    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int WIDE_W     = SLOT_W + mfq_pkg::ID_W;
    localparam int FIFO_DEPTH = mfq_pkg::LEVELS * TASK_SLOTS;
    localparam int FADDR_W    = $clog2(FIFO_DEPTH);
    localparam int LEVELS     = mfq_pkg::LEVELS;
    localparam int LEVEL_W    = mfq_pkg::LEVEL_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(TASK_SLOTS);
    localparam logic [WIDE_W-1:0]  SLOTS_WIDE = WIDE_W'(TASK_SLOTS);
    localparam logic [LEVEL_W-1:0] LAST_LVL   = LEVEL_W'(mfq_pkg::LAST_LEVEL);

    mfq_pkg::cfg_t cfg;

    // control state
    logic [1:0]                 state_reg, state_next;
    logic [mfq_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [mfq_pkg::ID_W-1:0]   id_reg, id_next;
    logic [mfq_pkg::REM_W-1:0]  need_reg, need_next;
    logic [LEVEL_W-1:0]         lvl_reg, lvl_next;
    logic                       any_reg, any_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [SLOT_W-1:0]          head_reg [LEVELS];
    logic [SLOT_W-1:0]          head_next [LEVELS];
    logic [SLOT_W-1:0]          tail_reg [LEVELS];
    logic [SLOT_W-1:0]          tail_next [LEVELS];
    logic [CNT_W-1:0]           count_reg [LEVELS];
    logic [CNT_W-1:0]           count_next [LEVELS];
    logic [TASK_SLOTS-1:0]      active_reg, active_next;
    logic                       run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]          run_slot_reg, run_slot_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [mfq_pkg::EV_W-1:0]    m_event_reg, m_event_next;
    logic [mfq_pkg::ID_W-1:0]    m_slot_reg, m_slot_next;
    logic [LEVEL_W-1:0]          m_level_reg, m_level_next;
    logic [mfq_pkg::SLICE_W-1:0] m_run_reg, m_run_next;
    logic [mfq_pkg::REM_W-1:0]   m_left_reg, m_left_next;

    // memory ports
    logic                             f_we, f_re;
    logic [FADDR_W-1:0]               f_waddr, f_raddr;
    logic [SLOT_W-1:0]                f_rdata;
    logic                             t_we, t_re;
    logic [SLOT_W-1:0]                t_waddr, t_raddr;
    mfq_pkg::task_entry_t             t_wdata, t_rdata;

    logic                accept, out_free, exec_fire;
    logic [LEVEL_W-1:0]  sel_lvl;
    logic                sel_any;
    logic [WIDE_W-1:0]   id_wide, id_reg_wide, slot_wide;
    logic [SLOT_W-1:0]   id_slot;
    logic                id_ok;
    logic                push_en;
    logic [LEVEL_W-1:0]  push_lvl;
    logic [mfq_pkg::REM_W-1:0]   quantum, grant;
    logic [mfq_pkg::STREAK_W-1:0] streak_new;
    logic [LEVEL_W-1:0]  lvl_new;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        r = (p == SLOT_LAST) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [FADDR_W-1:0] fifo_addr(input logic [LEVEL_W-1:0] l,
                                                     input logic [SLOT_W-1:0] p);
        int a;
        a = int'(l) * TASK_SLOTS + int'(p);
        return FADDR_W'(a);
    endfunction

    mfq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfq_ram #(.WIDTH(SLOT_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (slot_reg),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    mfq_ram #(.WIDTH(mfq_pkg::TASK_ENTRY_W), .DEPTH(TASK_SLOTS)) u_task_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;
    assign exec_fire = (state_reg == ST_EXEC) & out_free;

    assign id_wide     = WIDE_W'(s_task_id);
    assign id_slot     = id_wide[SLOT_W-1:0];
    assign id_reg_wide = WIDE_W'(id_reg);
    assign id_ok       = id_reg_wide < SLOTS_WIDE;
    assign slot_wide   = WIDE_W'(slot_reg);

    // lowest-numbered non-empty level
    always_comb begin
        sel_lvl = '0;
        sel_any = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                sel_lvl = LEVEL_W'(i);
                sel_any = 1'b1;
            end
        end
    end

    // memory reads: queue head at a dispatch transfer, task entry at transfer or after the pop
    assign f_re    = accept & (s_mode == mfq_pkg::MODE_DISPATCH) & ~run_valid_reg & sel_any;
    assign f_raddr = fifo_addr(sel_lvl, head_reg[sel_lvl]);
    assign t_re    = accept | (state_reg == ST_POP);
    always_comb begin
        priority if (state_reg == ST_POP) begin
            t_raddr = f_rdata;
        end else if (s_mode == mfq_pkg::MODE_ARRIVAL) begin
            t_raddr = id_slot;
        end else begin
            t_raddr = run_slot_reg;
        end
    end

    assign quantum = mfq_pkg::REM_W'(cfg.slice[lvl_reg]);
    assign grant   = (t_rdata.remaining < quantum) ? t_rdata.remaining : quantum;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        need_next      = need_reg;
        lvl_next       = lvl_reg;
        any_next       = any_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_event_next   = m_event_reg;
        m_slot_next    = m_slot_reg;
        m_level_next   = m_level_reg;
        m_run_next     = m_run_reg;
        m_left_next    = m_left_reg;
        t_we           = 1'b0;
        t_waddr        = slot_reg;
        t_wdata        = t_rdata;
        push_en        = 1'b0;
        push_lvl       = '0;
        streak_new     = '0;
        lvl_new        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next = s_mode;
                    id_next   = s_task_id;
                    need_next = s_service_need;
                    lvl_next  = sel_lvl;
                    any_next  = sel_any;
                    slot_next = (s_mode == mfq_pkg::MODE_ARRIVAL) ? id_slot : run_slot_reg;
                    state_next = f_re ? ST_POP : ST_EXEC;
                end
            end
            ST_POP: begin
                slot_next  = f_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_event_next = mfq_pkg::EV_REJECTED;
                    m_slot_next  = '0;
                    m_level_next = '0;
                    m_run_next   = '0;
                    m_left_next  = '0;
                    unique case (mode_reg)
                        mfq_pkg::MODE_ARRIVAL: begin
                            if (!id_ok) begin
                                m_event_next = mfq_pkg::EV_REJECTED;
                            end else if (active_reg[slot_reg]) begin
                                m_event_next = mfq_pkg::EV_REJECTED;
                                m_slot_next  = slot_wide[mfq_pkg::ID_W-1:0];
                                m_level_next = t_rdata.level;
                                m_left_next  = t_rdata.remaining;
                            end else begin
                                active_next[slot_reg] = 1'b1;
                                t_we              = 1'b1;
                                t_wdata.remaining = need_reg;
                                t_wdata.level     = '0;
                                t_wdata.streak    = '0;
                                push_en           = 1'b1;
                                push_lvl          = '0;
                                m_event_next = mfq_pkg::EV_ACCEPTED;
                                m_slot_next  = slot_wide[mfq_pkg::ID_W-1:0];
                                m_left_next  = need_reg;
                            end
                        end
                        mfq_pkg::MODE_DISPATCH: begin
                            if (run_valid_reg) begin
                                m_event_next = mfq_pkg::EV_BUSY;
                                m_slot_next  = slot_wide[mfq_pkg::ID_W-1:0];
                                m_level_next = t_rdata.level;
                                m_left_next  = t_rdata.remaining;
                            end else if (!any_reg) begin
                                m_event_next = mfq_pkg::EV_IDLE;
                            end else begin
                                if (lvl_reg == LAST_LVL) begin
                                    streak_new = (t_rdata.streak == mfq_pkg::STREAK_MAX) ?
                                                 t_rdata.streak : t_rdata.streak + 1'b1;
                                end
                                t_we              = 1'b1;
                                t_wdata.remaining = t_rdata.remaining - grant;
                                t_wdata.level     = lvl_reg;
                                t_wdata.streak    = streak_new;
                                head_next[lvl_reg]  = wrap_inc(head_reg[lvl_reg]);
                                count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                                run_valid_next = 1'b1;
                                run_slot_next  = slot_reg;
                                m_event_next = mfq_pkg::EV_DISPATCHED;
                                m_slot_next  = slot_wide[mfq_pkg::ID_W-1:0];
                                m_level_next = lvl_reg;
                                m_run_next   = grant[mfq_pkg::SLICE_W-1:0];
                                m_left_next  = t_rdata.remaining - grant;
                            end
                        end
                        mfq_pkg::MODE_RETIRE: begin
                            if (!run_valid_reg) begin
                                m_event_next = mfq_pkg::EV_NOT_RUNNING;
                            end else begin
                                run_valid_next = 1'b0;
                                m_slot_next    = slot_wide[mfq_pkg::ID_W-1:0];
                                if (t_rdata.remaining == '0) begin
                                    active_next[slot_reg] = 1'b0;
                                    m_event_next = mfq_pkg::EV_COMPLETED;
                                    m_level_next = t_rdata.level;
                                end else begin
                                    streak_new = t_rdata.streak;
                                    priority if (t_rdata.level < LAST_LVL) begin
                                        lvl_new    = t_rdata.level + 1'b1;
                                        streak_new = '0;
                                    end else if (t_rdata.streak >=
                                                 mfq_pkg::STREAK_W'(cfg.threshold)) begin
                                        lvl_new    = '0;
                                        streak_new = '0;
                                    end else begin
                                        lvl_new = LAST_LVL;
                                    end
                                    t_we           = 1'b1;
                                    t_wdata.level  = lvl_new;
                                    t_wdata.streak = streak_new;
                                    push_en        = 1'b1;
                                    push_lvl       = lvl_new;
                                    m_event_next = mfq_pkg::EV_REQUEUED;
                                    m_level_next = lvl_new;
                                    m_left_next  = t_rdata.remaining;
                                end
                            end
                        end
                        default: begin
                            m_event_next = mfq_pkg::EV_REJECTED;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // drop a push into a full queue
        if (push_en && count_reg[push_lvl] != CNT_FULL) begin
            tail_next[push_lvl]  = wrap_inc(tail_reg[push_lvl]);
            count_next[push_lvl] = count_reg[push_lvl] + 1'b1;
        end
    end

    assign f_we    = exec_fire & push_en & (count_reg[push_lvl] != CNT_FULL);
    assign f_waddr = fifo_addr(push_lvl, tail_reg[push_lvl]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            m_valid_reg   <= m_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        id_reg      <= id_next;
        need_reg    <= need_next;
        lvl_reg     <= lvl_next;
        any_reg     <= any_next;
        slot_reg    <= slot_next;
        m_event_reg <= m_event_next;
        m_slot_reg  <= m_slot_next;
        m_level_reg <= m_level_next;
        m_run_reg   <= m_run_next;
        m_left_reg  <= m_left_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_res  = m_event_reg;
    assign m_task_slot  = m_slot_reg;
    assign m_level      = m_level_reg;
    assign m_run_length = m_run_reg;
    assign m_units_left = m_left_reg;

endmodule

@@ rtl/core/mfq_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mfq_cfg.sv @@
// APB-style configuration registers: five level slices and the return threshold.
// Depends on mfq_pkg.
module mfq_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mfq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mfq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output mfq_pkg::cfg_t                  cfg
);

    mfq_pkg::cfg_t cfg_reg;
    mfq_pkg::cfg_t cfg_next;
    logic [mfq_pkg::CFG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx   = paddr[mfq_pkg::CFG_ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            priority if (idx == mfq_pkg::REG_THRESHOLD) begin
                cfg_next.threshold = pwdata[mfq_pkg::THR_W-1:0];
            end else if (idx <= mfq_pkg::REG_SLICE4) begin
                cfg_next.slice[idx] = pwdata[mfq_pkg::SLICE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slice[0]  <= mfq_pkg::SLICE0_RST;
            cfg_reg.slice[1]  <= mfq_pkg::SLICE1_RST;
            cfg_reg.slice[2]  <= mfq_pkg::SLICE2_RST;
            cfg_reg.slice[3]  <= mfq_pkg::SLICE3_RST;
            cfg_reg.slice[4]  <= mfq_pkg::SLICE4_RST;
            cfg_reg.threshold <= mfq_pkg::THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        priority if (idx == mfq_pkg::REG_THRESHOLD) begin
            prdata = mfq_pkg::CFG_DATA_W'(cfg_reg.threshold);
        end else if (idx <= mfq_pkg::REG_SLICE4) begin
            prdata = mfq_pkg::CFG_DATA_W'(cfg_reg.slice[idx]);
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule
